[rtl/bilinear_thumbnail_resize_defines.svh]
// assertion macros for the bilinear thumbnail resizer
`ifndef BILINEAR_THUMBNAIL_RESIZE_DEFINES_SVH
`define BILINEAR_THUMBNAIL_RESIZE_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define BTR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define BTR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/btr_pkg.sv]
// shared constants and register codes of the bilinear thumbnail resizer
`default_nettype none
package btr_pkg;
  localparam int BTR_MAX_SOURCE_WIDTH  = 256;
  localparam int BTR_MAX_SOURCE_HEIGHT = 256;
  localparam int BTR_WEIGHT_FRAC_BITS  = 8;

  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 4;
  localparam int THUMB_MAX  = 256;
  localparam int STORE_AW   = 16;
  localparam int PIX_W      = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_THUMB_WIDTH   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_THUMB_HEIGHT  = CFG_IDX_W'(3);

  localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = CFG_W'(256);
  localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = CFG_W'(256);
  localparam logic [CFG_W-1:0] RST_THUMB_WIDTH   = CFG_W'(32);
  localparam logic [CFG_W-1:0] RST_THUMB_HEIGHT  = CFG_W'(32);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;
endpackage
`default_nettype wire

[rtl/btr_ram.sv]
// generic single-port ram with registered read
`default_nettype none
module btr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/bilinear_thumbnail_resize.sv]
// top level of the bilinear thumbnail resizer
`default_nettype none
`include "bilinear_thumbnail_resize_defines.svh"
// Bilinear thumbnail resizer. Loads (func=0) write one pixel into a 64K x 24 single-port
// image memory from the idle state; they give no result. Queries (func=1) map the
// thumbnail coordinate with half-pixel centers through two restoring dividers that run
// side by side, one quotient bit per cycle, over 9 + clog2(max source size + 1) +
// WEIGHT_FRAC_BITS steps (26 at the defaults), then register the neighbor addresses,
// then the weights, read the four neighbors in turn through the one memory port and
// deliver the result. Queries outside the thumbnail skip the dividers and go straight
// to delivery. A one-beat input buffer and an output register let the next beat in
// while a result waits. Never-written memory entries read as whatever they hold.
module bilinear_thumbnail_resize
  import btr_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH  = BTR_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = BTR_MAX_SOURCE_HEIGHT,
  parameter int WEIGHT_FRAC_BITS  = BTR_WEIGHT_FRAC_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 func,
  input  wire logic [15:0]          load_index,
  input  wire logic [7:0]           chan0_in,
  input  wire logic [7:0]           chan1_in,
  input  wire logic [7:0]           chan2_in,
  input  wire logic [7:0]           out_x,
  input  wire logic [7:0]           out_y,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                chan0_out,
  output logic [7:0]                chan1_out,
  output logic [7:0]                chan2_out,
  output logic [7:0]                luma,
  output logic                      out_of_range,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);
  localparam int F    = WEIGHT_FRAC_BITS;
  localparam int SMAX = (MAX_SOURCE_WIDTH > MAX_SOURCE_HEIGHT) ?
                        MAX_SOURCE_WIDTH : MAX_SOURCE_HEIGHT;
  localparam int SMW  = $clog2(SMAX + 1);
  localparam int TW   = $clog2(THUMB_MAX + 1);
  localparam int SCW  = 9 + SMW;
  localparam int NW   = SCW + F;
  localparam int DW   = TW + 1;
  localparam int RW   = DW + 1;
  localparam int CW   = $clog2(NW + 1);
  localparam int WW   = F + 1;
  localparam int PW   = 2 * WW;
  localparam int ACW  = 8 + PW;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_ADDR, S_WGT, S_READ, S_FIN} state_t;

  // one restoring division step
  function automatic logic [RW+NW-1:0] div_step(input logic [RW-1:0] r,
                                                input logic [NW-1:0] n,
                                                input logic [DW-1:0] d);
    logic [RW-1:0] rs;
    logic          b;
    rs = {r[RW-2:0], n[NW-1]};
    b  = (rs >= {1'b0, d});
    if (b) begin
      rs = rs - {1'b0, d};
    end
    return {rs, n[NW-2:0], b};
  endfunction

  // configuration registers
  logic [CFG_W-1:0] source_width, source_height, thumb_width, thumb_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RST_SOURCE_WIDTH;
      source_height <= RST_SOURCE_HEIGHT;
      thumb_width   <= RST_THUMB_WIDTH;
      thumb_height  <= RST_THUMB_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_THUMB_WIDTH:   thumb_width   <= cfg_data;
        REG_THUMB_HEIGHT:  thumb_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes clamped to their legal ranges
  logic [SMW-1:0] sw_c, sh_c;
  logic [TW-1:0]  tw_c, th_c;

  always_comb begin
    if (source_width == '0) sw_c = SMW'(1);
    else if (32'(source_width) > 32'(MAX_SOURCE_WIDTH)) sw_c = SMW'(MAX_SOURCE_WIDTH);
    else sw_c = SMW'(source_width);
    if (source_height == '0) sh_c = SMW'(1);
    else if (32'(source_height) > 32'(MAX_SOURCE_HEIGHT)) sh_c = SMW'(MAX_SOURCE_HEIGHT);
    else sh_c = SMW'(source_height);
    if (thumb_width == '0) tw_c = TW'(1);
    else if (32'(thumb_width) > 32'(THUMB_MAX)) tw_c = TW'(THUMB_MAX);
    else tw_c = TW'(thumb_width);
    if (thumb_height == '0) th_c = TW'(1);
    else if (32'(thumb_height) > 32'(THUMB_MAX)) th_c = TW'(THUMB_MAX);
    else th_c = TW'(thumb_height);
  end

  // input buffer
  logic        buf_valid, buf_func;
  logic [15:0] buf_index;
  logic [7:0]  buf_c0, buf_c1, buf_c2, buf_x, buf_y;
  logic        take;
  state_t      state;

  assign take     = (state == S_IDLE) && buf_valid;
  assign in_stall = buf_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      buf_valid <= 1'b1;
    end else if (take) begin
      buf_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      buf_func  <= func;
      buf_index <= load_index;
      buf_c0    <= chan0_in;
      buf_c1    <= chan1_in;
      buf_c2    <= chan2_in;
      buf_x     <= out_x;
      buf_y     <= out_y;
    end
  end

  // query start: scaled half-pixel positions
  logic [SCW-1:0] scl_x, scl_y;
  logic           oor;

  assign scl_x = SCW'({buf_x, 1'b1}) * SCW'(sw_c);
  assign scl_y = SCW'({buf_y, 1'b1}) * SCW'(sh_c);
  assign oor   = (TW'(buf_x) >= tw_c) || (TW'(buf_y) >= th_c);

  // datapath registers
  logic [SMW-1:0]      sw_q, sh_q;
  logic [DW-1:0]       dx, dy;
  logic [RW-1:0]       rx, ry;
  logic [NW-1:0]       qx, qy;
  logic [CW-1:0]       div_cnt;
  logic [SMW-1:0]      col_lo, col_hi;
  logic [STORE_AW-1:0] rbase_lo, rbase_hi;
  logic [F-1:0]        fx, fy;
  logic [PW-1:0]       wgt [4];
  logic [ACW-1:0]      acc [3];
  logic [2:0]          rd_cnt;
  logic                oor_q;

  // neighbor coordinates from the quotients
  logic [SCW-1:0] colw, roww;
  logic [SMW-1:0] c_lo, r_lo, c_hi, r_hi, sw_m1, sh_m1;

  assign colw  = qx[NW-1:F];
  assign roww  = qy[NW-1:F];
  assign sw_m1 = sw_q - SMW'(1);
  assign sh_m1 = sh_q - SMW'(1);

  always_comb begin
    c_lo = (colw > SCW'(sw_m1)) ? sw_m1 : SMW'(colw);
    r_lo = (roww > SCW'(sh_m1)) ? sh_m1 : SMW'(roww);
    c_hi = (({1'b0, c_lo} + (SMW+1)'(1)) < {1'b0, sw_m1}) ? c_lo + SMW'(1) : sw_m1;
    r_hi = (({1'b0, r_lo} + (SMW+1)'(1)) < {1'b0, sh_m1}) ? r_lo + SMW'(1) : sh_m1;
  end

  // weights and memory access
  logic [WW-1:0]       wx0, wy0, wx1, wy1;
  logic [1:0]          widx;
  logic                ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [PIX_W-1:0]    ram_rdata;

  assign wx1  = WW'(fx);
  assign wy1  = WW'(fy);
  assign wx0  = (WW'(1) << F) - wx1;
  assign wy0  = (WW'(1) << F) - wy1;
  assign widx = 2'(rd_cnt - 3'd1);

  assign ram_we = take && (buf_func == FUNC_LOAD);

  always_comb begin
    ram_addr = buf_index;
    if (state == S_READ) begin
      case (rd_cnt[1:0])
        2'd0:    ram_addr = rbase_lo + STORE_AW'(col_lo);
        2'd1:    ram_addr = rbase_lo + STORE_AW'(col_hi);
        2'd2:    ram_addr = rbase_hi + STORE_AW'(col_lo);
        default: ram_addr = rbase_hi + STORE_AW'(col_hi);
      endcase
    end
  end

  btr_ram #(.WIDTH(PIX_W), .DEPTH(2 ** STORE_AW)) u_image (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({buf_c2, buf_c1, buf_c0}),
    .rdata (ram_rdata)
  );

  // result channels and luma
  logic [7:0]  ch0, ch1, ch2;
  logic [15:0] luma_sum;

  assign ch0      = acc[0][2*F +: 8];
  assign ch1      = acc[1][2*F +: 8];
  assign ch2      = acc[2][2*F +: 8];
  assign luma_sum = 16'(16'd77 * ch0) + 16'(16'd150 * ch1) + 16'(16'd29 * ch2);

  // control sequence and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_cnt   <= '0;
      rd_cnt    <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take && buf_func == FUNC_QUERY) begin
            oor_q <= oor;
            sw_q  <= sw_c;
            sh_q  <= sh_c;
            dx    <= {tw_c, 1'b0};
            dy    <= {th_c, 1'b0};
            rx    <= '0;
            ry    <= '0;
            qx    <= (scl_x > SCW'(tw_c)) ? {scl_x - SCW'(tw_c), F'(0)} : '0;
            qy    <= (scl_y > SCW'(th_c)) ? {scl_y - SCW'(th_c), F'(0)} : '0;
            if (oor) begin
              state <= S_FIN;
            end else begin
              div_cnt <= CW'(NW);
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          {rx, qx} <= div_step(rx, qx, dx);
          {ry, qy} <= div_step(ry, qy, dy);
          div_cnt  <= div_cnt - CW'(1);
          if (div_cnt == CW'(1)) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          col_lo   <= c_lo;
          col_hi   <= c_hi;
          rbase_lo <= STORE_AW'(r_lo) * STORE_AW'(sw_q);
          rbase_hi <= STORE_AW'(r_hi) * STORE_AW'(sw_q);
          fx       <= qx[F-1:0];
          fy       <= qy[F-1:0];
          state    <= S_WGT;
        end
        S_WGT: begin
          wgt[0] <= PW'(wx0) * PW'(wy0);
          wgt[1] <= PW'(wx1) * PW'(wy0);
          wgt[2] <= PW'(wx0) * PW'(wy1);
          wgt[3] <= PW'(wx1) * PW'(wy1);
          acc[0] <= '0;
          acc[1] <= '0;
          acc[2] <= '0;
          rd_cnt <= '0;
          state  <= S_READ;
        end
        S_READ: begin
          // read data of the previous address comes back this cycle
          if (rd_cnt != 3'd0) begin
            acc[0] <= acc[0] + ACW'(ram_rdata[7:0])   * ACW'(wgt[widx]);
            acc[1] <= acc[1] + ACW'(ram_rdata[15:8])  * ACW'(wgt[widx]);
            acc[2] <= acc[2] + ACW'(ram_rdata[23:16]) * ACW'(wgt[widx]);
          end
          rd_cnt <= rd_cnt + 3'd1;
          if (rd_cnt == 3'd4) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            out_of_range <= oor_q;
            chan0_out    <= oor_q ? 8'd0 : ch0;
            chan1_out    <= oor_q ? 8'd0 : ch1;
            chan2_out    <= oor_q ? 8'd0 : ch2;
            luma         <= oor_q ? 8'd0 : luma_sum[15:8];
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `BTR_ASSERT_NOW(a_div_only_in_div, clk, rst, div_cnt != '0, state == S_DIV, "divider busy outside divide")
  `BTR_ASSERT_NOW(a_no_write_in_read, clk, rst, state == S_READ, !ram_we, "memory write during neighbor reads")
  `BTR_ASSERT_NOW(a_oor_zero, clk, rst, out_valid && out_of_range, chan0_out == 8'd0 && luma == 8'd0, "out-of-range beat carries data")
  `BTR_ASSERT_NEXT(a_fin_to_idle, clk, rst, state == S_FIN && !out_valid, state == S_IDLE && out_valid, "result not delivered")
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the bilinear thumbnail resizer
module tb_top;
  import btr_pkg::*;

  typedef struct packed {
    logic       func;
    logic [15:0] idx;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] x;
    logic [7:0] y;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] luma;
    logic       oor;
  } thumb_px_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = FUNC_LOAD;
  logic [15:0] load_index = '0;
  logic [7:0] chan0_in = '0, chan1_in = '0, chan2_in = '0;
  logic [7:0] out_x = '0, out_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] chan0_out, chan1_out, chan2_out, luma;
  logic out_of_range;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  bilinear_thumbnail_resize u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .load_index(load_index),
    .chan0_in(chan0_in), .chan1_in(chan1_in), .chan2_in(chan2_in),
    .out_x(out_x), .out_y(out_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .chan0_out(chan0_out), .chan1_out(chan1_out), .chan2_out(chan2_out),
    .luma(luma), .out_of_range(out_of_range),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // shadow of the image store and the size registers
  logic [PIX_W-1:0] image_mem [0:65535];
  bit filled [0:65535];
  logic [CFG_W-1:0] src_w_reg = RST_SOURCE_WIDTH, src_h_reg = RST_SOURCE_HEIGHT;
  logic [CFG_W-1:0] thb_w_reg = RST_THUMB_WIDTH, thb_h_reg = RST_THUMB_HEIGHT;

  pixel_req_t pending_reqs [$];
  thumb_px_t  expected_px [$];
  int  errors = 0;
  int  cycles = 0;
  logic in_took = 1'b0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;

  function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // source position with 8 fractional bits, half-pixel centers
  function automatic longint unsigned src_pos(int unsigned o, int unsigned s,
                                              int unsigned t);
    longint unsigned scaled;
    scaled = (2 * longint'(o) + 1) * s;
    if (scaled <= t) return 0;
    return ((scaled - t) << BTR_WEIGHT_FRAC_BITS) / (2 * longint'(t));
  endfunction

  // bilinear blend of one thumbnail pixel from the shadow store
  function automatic thumb_px_t blend_pixel(pixel_req_t r);
    thumb_px_t res;
    int unsigned sw, sh, tw, th, col_lo, col_hi, row_lo, row_hi;
    longint unsigned px, py, fx, fy, wx0, wy0, acc;
    logic [PIX_W-1:0] p00, p01, p10, p11;
    logic [7:0] ch [3];
    sw = eff_size(src_w_reg, BTR_MAX_SOURCE_WIDTH);
    sh = eff_size(src_h_reg, BTR_MAX_SOURCE_HEIGHT);
    tw = eff_size(thb_w_reg, THUMB_MAX);
    th = eff_size(thb_h_reg, THUMB_MAX);
    res = '0;
    if (r.x >= tw || r.y >= th) begin
      res.oor = 1'b1;
      return res;
    end
    px = src_pos(r.x, sw, tw);
    py = src_pos(r.y, sh, th);
    col_lo = 32'(px >> BTR_WEIGHT_FRAC_BITS);
    row_lo = 32'(py >> BTR_WEIGHT_FRAC_BITS);
    if (col_lo > sw - 1) col_lo = sw - 1;
    if (row_lo > sh - 1) row_lo = sh - 1;
    fx = px & ((1 << BTR_WEIGHT_FRAC_BITS) - 1);
    fy = py & ((1 << BTR_WEIGHT_FRAC_BITS) - 1);
    col_hi = (col_lo + 1 < sw - 1) ? col_lo + 1 : sw - 1;
    row_hi = (row_lo + 1 < sh - 1) ? row_lo + 1 : sh - 1;
    wx0 = (1 << BTR_WEIGHT_FRAC_BITS) - fx;
    wy0 = (1 << BTR_WEIGHT_FRAC_BITS) - fy;
    p00 = image_mem[16'(row_lo * sw + col_lo)];
    p01 = image_mem[16'(row_lo * sw + col_hi)];
    p10 = image_mem[16'(row_hi * sw + col_lo)];
    p11 = image_mem[16'(row_hi * sw + col_hi)];
    for (int c = 0; c < 3; c++) begin
      acc = p00[8*c +: 8] * wx0 * wy0 + p01[8*c +: 8] * fx * wy0
          + p10[8*c +: 8] * wx0 * fy + p11[8*c +: 8] * fx * fy;
      ch[c] = 8'(acc >> (2 * BTR_WEIGHT_FRAC_BITS));
    end
    res.c0 = ch[0];
    res.c1 = ch[1];
    res.c2 = ch[2];
    res.luma = 8'((77 * ch[0] + 150 * ch[1] + 29 * ch[2]) >> 8);
    return res;
  endfunction

  // store addresses of the four neighbors of an in-range query at the current sizes
  function automatic logic [63:0] nbr_addrs(int unsigned x, int unsigned y);
    int unsigned sw, sh, tw, th, col_lo, col_hi, row_lo, row_hi;
    sw = eff_size(src_w_reg, BTR_MAX_SOURCE_WIDTH);
    sh = eff_size(src_h_reg, BTR_MAX_SOURCE_HEIGHT);
    tw = eff_size(thb_w_reg, THUMB_MAX);
    th = eff_size(thb_h_reg, THUMB_MAX);
    col_lo = 32'(src_pos(x, sw, tw) >> BTR_WEIGHT_FRAC_BITS);
    row_lo = 32'(src_pos(y, sh, th) >> BTR_WEIGHT_FRAC_BITS);
    if (col_lo > sw - 1) col_lo = sw - 1;
    if (row_lo > sh - 1) row_lo = sh - 1;
    col_hi = (col_lo + 1 < sw - 1) ? col_lo + 1 : sw - 1;
    row_hi = (row_lo + 1 < sh - 1) ? row_lo + 1 : sh - 1;
    return {16'(row_hi * sw + col_hi), 16'(row_hi * sw + col_lo),
            16'(row_lo * sw + col_hi), 16'(row_lo * sw + col_lo)};
  endfunction

  // accepted input beats update the shadow store or queue a prediction
  always @(posedge clk) begin
    in_took <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      if (func == FUNC_LOAD) image_mem[load_index] = {chan2_in, chan1_in, chan0_in};
      else expected_px.insert(expected_px.size(),
                              blend_pixel({func, load_index, chan0_in, chan1_in,
                                           chan2_in, out_x, out_y}));
    end
  end

  // input driver with random gaps
  int gap_left = 0;
  always @(negedge clk) begin
    pixel_req_t r;
    int roll;
    if (!rst && (!in_valid || in_took)) begin
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        func <= r.func;
        load_index <= r.idx;
        chan0_in <= r.c0;
        chan1_in <= r.c1;
        chan2_in <= r.c2;
        out_x <= r.x;
        out_y <= r.y;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60) gap_left = 0;
        else if (roll < 92) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(4, 40);
      end
    end
  end

  // output stall pattern, with one long hold-off on request
  int stall_left = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    int roll;
    if (hold_req) begin
      hold_left = 500;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (quiet || roll < 65) stall_left = 0;
      else if (roll < 93) stall_left = $urandom_range(1, 3);
      else stall_left = $urandom_range(4, 50);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // result checker
  always @(posedge clk) begin
    thumb_px_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_px.size() == 0) begin
        $display("%0t: unexpected result beat c0=%0d c1=%0d c2=%0d luma=%0d oor=%0d",
                 $time, chan0_out, chan1_out, chan2_out, luma, out_of_range);
        errors++;
      end else begin
        e = expected_px.pop_front();
        if (e.c0 !== chan0_out) begin
          $display("%0t: chan0 exp %0d got %0d", $time, e.c0, chan0_out); errors++;
        end
        if (e.c1 !== chan1_out) begin
          $display("%0t: chan1 exp %0d got %0d", $time, e.c1, chan1_out); errors++;
        end
        if (e.c2 !== chan2_out) begin
          $display("%0t: chan2 exp %0d got %0d", $time, e.c2, chan2_out); errors++;
        end
        if (e.luma !== luma) begin
          $display("%0t: luma exp %0d got %0d", $time, e.luma, luma); errors++;
        end
        if (e.oor !== out_of_range) begin
          $display("%0t: out_of_range exp %0d got %0d", $time, e.oor, out_of_range);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_load(int unsigned idx, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    pixel_req_t r;
    r = {FUNC_LOAD, 16'(idx), a, b, c, 8'($urandom), 8'($urandom)};
    filled[16'(idx)] = 1'b1;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // in-range queries first load any neighbor that has not been written yet
  task automatic push_query(int unsigned x, int unsigned y);
    pixel_req_t r;
    logic [63:0] na;
    if (x < eff_size(thb_w_reg, THUMB_MAX) && y < eff_size(thb_h_reg, THUMB_MAX)) begin
      na = nbr_addrs(x, y);
      for (int k = 0; k < 4; k++) begin
        if (!filled[na[16*k +: 16]]) begin
          push_load(na[16*k +: 16], 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end
    r = {FUNC_QUERY, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
         8'(x), 8'(y)};
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // register write, applied to the shadow copy on the handshake
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SOURCE_WIDTH:  src_w_reg = val;
      REG_SOURCE_HEIGHT: src_h_reg = val;
      REG_THUMB_WIDTH:   thb_w_reg = val;
      REG_THUMB_HEIGHT:  thb_h_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned tw,
                           int unsigned th);
    write_reg(REG_SOURCE_WIDTH, CFG_W'(sw));
    write_reg(REG_SOURCE_HEIGHT, CFG_W'(sh));
    write_reg(REG_THUMB_WIDTH, CFG_W'(tw));
    write_reg(REG_THUMB_HEIGHT, CFG_W'(th));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every beat is in and every result is out, then let the block settle
  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_px.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  // random mix of loads and queries, mostly inside the thumbnail
  task automatic random_phase(int n);
    int unsigned tw, th;
    tw = eff_size(thb_w_reg, THUMB_MAX);
    th = eff_size(thb_h_reg, THUMB_MAX);
    repeat (n) begin
      if ($urandom_range(0, 99) < 20) begin
        push_load($urandom_range(0, 65535), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if ($urandom_range(0, 99) < 85) begin
        push_query($urandom_range(0, (tw > 254) ? 255 : tw + 1),
                   $urandom_range(0, (th > 254) ? 255 : th + 1));
      end else begin
        push_query($urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed queries at reset sizes, back to back: corners, edges and outside
    quiet = 1'b1;
    push_load(0, 8'hff, 8'hff, 8'hff);
    push_query(0, 0);
    push_query(31, 31);
    push_query(0, 31);
    push_query(31, 0);
    push_query(32, 0);
    push_query(0, 32);
    push_query(255, 255);
    push_query(16, 16);
    push_load(0, 8'h00, 8'hff, 8'h80);
    push_query(0, 0);
    drain();
    quiet = 1'b0;

    // unknown register indexes must not disturb anything
    write_reg(CFG_IDX_W'(4), 9'h1ff);
    write_reg(CFG_IDX_W'(15), 9'h000);
    @(negedge clk);
    cfg_valid <= 1'b0;
    push_query(1, 1);
    random_phase(50);
    drain();

    // one-pixel everything, and zero acting as one
    set_sizes(1, 1, 1, 1);
    push_query(0, 0);
    push_query(1, 0);
    push_query(0, 1);
    random_phase(20);
    drain();
    set_sizes(0, 0, 0, 0);
    push_query(0, 0);
    push_query(0, 1);
    random_phase(20);
    drain();

    // saturated sizes, with a long output hold-off to back up the input
    set_sizes(511, 511, 511, 511);
    push_query(255, 255);
    push_query(0, 255);
    hold_req = 1'b1;
    random_phase(80);
    drain();

    set_sizes(256, 256, 256, 256);
    push_query(255, 0);
    random_phase(60);
    drain();

    // upscale and mixed aspect ratios
    set_sizes(7, 5, 13, 3);
    random_phase(60);
    drain();
    set_sizes(256, 200, 17, 256);
    random_phase(60);
    drain();
    set_sizes(2, 256, 256, 1);
    random_phase(40);
    drain();

    for (int k = 0; k < 3; k++) begin
      set_sizes($urandom_range(1, 256), $urandom_range(1, 256), $urandom_range(1, 64),
                $urandom_range(1, 64));
      random_phase(30);
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && expected_px.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/btr_pkg.sv
rtl/btr_ram.sv
rtl/bilinear_thumbnail_resize.sv
tb/sv/tb_top.sv
